/* sv/framed_serial_transmitter_assert.svh */
// Assertion macros shared by the transmitter RTL.
`ifndef FRAMED_SERIAL_TRANSMITTER_ASSERT_SVH
`define FRAMED_SERIAL_TRANSMITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FST_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/fst_pkg.sv */
package fst_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [3:0] BIT_START      = 4'd0;
  localparam logic [3:0] BIT_PARITY     = 4'd9;
  localparam logic [3:0] TICKS_PER_BYTE = 4'd12;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] cmd;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic        tx_line;
    logic        busy_res;
    logic        frame_done;
    logic        rejected;
    logic [15:0] frames_sent;
  } result_t;

  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, b[i]};
    end
    return n;
  endfunction

endpackage

/* sv/framed_serial_transmitter.sv */
// The result of a transaction is registered and offered the next cycle.
// One transaction is taken per cycle while the result side takes every result.
// A payload byte is read from the store on its start-bit tick and is ready by the next tick.
// Reset is synchronous and active high; it idles the line high and clears counters.
// The payload store is not cleared; only bytes loaded for the current message are read.
module framed_serial_transmitter #(
  parameter int MAX_PAYLOAD = 15
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  fst_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_ready,
  output fst_pkg::result_t result
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [3:0]  payload_count, payload_count_next;
  logic [7:0]  header_byte, header_byte_next;
  logic [7:0]  ones_sum, ones_sum_next;
  logic [3:0]  bit_position, bit_position_next;
  logic [4:0]  byte_position, byte_position_next;
  logic        sending, sending_next;
  logic [15:0] sent_counter, sent_counter_next;
  logic        line_level, line_level_next;
  logic        fetch_pend;
  logic [7:0]  cur_byte;

  logic        accept;
  logic        wr_en, rd_en;
  logic [3:0]  rd_idx;
  logic [7:0]  rd_data;
  logic [7:0]  fetched;
  logic [7:0]  tx_byte;
  logic [2:0]  bit_idx;
  logic        done, rej;

  assign accept     = item_valid && item_ready;
  assign item_ready = !result_valid || result_ready;
  assign rd_idx     = byte_position[3:0] - 4'd1;
  assign bit_idx    = 3'(bit_position - 4'd1);
  assign fetched    = fetch_pend ? rd_data : cur_byte;

  always_comb begin
    if (byte_position == 5'd0) begin
      tx_byte = header_byte;
    end else if (byte_position <= {1'b0, payload_count}) begin
      tx_byte = fetched;
    end else begin
      tx_byte = ones_sum;
    end
  end

  always_comb begin
    payload_count_next = payload_count;
    header_byte_next   = header_byte;
    ones_sum_next      = ones_sum;
    bit_position_next  = bit_position;
    byte_position_next = byte_position;
    sending_next       = sending;
    sent_counter_next  = sent_counter;
    line_level_next    = line_level;
    wr_en              = 1'b0;
    rd_en              = 1'b0;
    done               = 1'b0;
    rej                = 1'b0;
    if (accept) begin
      case (item.op)
        fst_pkg::OP_LOAD: begin
          if (sending || (payload_count >= 4'(MAX_PAYLOAD))) begin
            rej = 1'b1;
          end else begin
            wr_en              = 1'b1;
            payload_count_next = payload_count + 4'd1;
            ones_sum_next      = ones_sum + {4'd0, fst_pkg::popcount8(item.data_byte)};
          end
        end
        fst_pkg::OP_START: begin
          if (sending) begin
            rej = 1'b1;
          end else begin
            header_byte_next   = {payload_count, item.cmd};
            ones_sum_next      = ones_sum
                               + {4'd0, fst_pkg::popcount8({payload_count, item.cmd})};
            bit_position_next  = 4'd0;
            byte_position_next = 5'd0;
            sending_next       = 1'b1;
          end
        end
        fst_pkg::OP_TICK: begin
          if (!sending) begin
            line_level_next = 1'b1;
          end else begin
            if (bit_position == fst_pkg::BIT_START) begin
              line_level_next = 1'b0;
              rd_en = (byte_position != 5'd0) && (byte_position <= {1'b0, payload_count});
            end else if (bit_position < fst_pkg::BIT_PARITY) begin
              line_level_next = tx_byte[bit_idx];
            end else if (bit_position == fst_pkg::BIT_PARITY) begin
              line_level_next = ^tx_byte;
            end else begin
              line_level_next = 1'b1;
            end
            bit_position_next = bit_position + 4'd1;
            if (bit_position_next >= fst_pkg::TICKS_PER_BYTE) begin
              bit_position_next  = 4'd0;
              byte_position_next = byte_position + 5'd1;
              if (byte_position_next >= ({1'b0, payload_count} + 5'd2)) begin
                sending_next       = 1'b0;
                byte_position_next = 5'd0;
                payload_count_next = 4'd0;
                ones_sum_next      = 8'd0;
                sent_counter_next  = sent_counter + 16'd1;
                done               = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  fst_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_payload_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(payload_count[AW-1:0]),
    .wr_data(item.data_byte),
    .rd_en  (rd_en),
    .rd_addr(rd_idx[AW-1:0]),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_count <= 4'd0;
      header_byte   <= 8'd0;
      ones_sum      <= 8'd0;
      bit_position  <= 4'd0;
      byte_position <= 5'd0;
      sending       <= 1'b0;
      sent_counter  <= 16'd0;
      line_level    <= 1'b1;
      fetch_pend    <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      payload_count <= payload_count_next;
      header_byte   <= header_byte_next;
      ones_sum      <= ones_sum_next;
      bit_position  <= bit_position_next;
      byte_position <= byte_position_next;
      sending       <= sending_next;
      sent_counter  <= sent_counter_next;
      line_level    <= line_level_next;
      fetch_pend    <= rd_en;
      if (accept) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_pend) begin
      cur_byte <= rd_data;
    end
    if (accept) begin
      result.tx_line     <= line_level_next;
      result.busy_res    <= sending_next;
      result.frame_done  <= done;
      result.rejected    <= rej;
      result.frames_sent <= sent_counter_next;
    end
  end

`include "framed_serial_transmitter_assert.svh"

  `FST_ASSERT_SAME(a_count_in_range, clk, rst, 1'b1, payload_count <= 4'(MAX_PAYLOAD), "payload count exceeds the maximum")
  `FST_ASSERT_SAME(a_bit_in_range, clk, rst, sending, bit_position < fst_pkg::TICKS_PER_BYTE, "bit position out of range")
  `FST_ASSERT_SAME(a_fetch_while_sending, clk, rst, fetch_pend, sending && (bit_position == 4'd1), "payload fetch outside a data byte")
  `FST_ASSERT_SAME(a_done_ends_frame, clk, rst, result_valid && result.frame_done, !result.busy_res && result.tx_line, "frame end without idle line")
  `FST_ASSERT_NEXT(a_load_busy_rejected, clk, rst, accept && sending && (item.op == fst_pkg::OP_LOAD), result_valid && result.rejected, "load during a frame was not rejected")

endmodule

/* sv/fst_ram.sv */
module fst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* tb/sv/fst_line_checker.sv */
module fst_line_checker #(
  parameter int MAX_PAYLOAD = 15
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_ready,
  input  fst_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_ready,
  input  fst_pkg::result_t result,
  output int               mismatches,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  msg_bytes [16];
  logic [3:0]  msg_len;
  logic [7:0]  hdr_byte;
  logic [7:0]  ones_total;
  logic [3:0]  tick_in_byte;
  logic [4:0]  byte_index;
  logic        in_frame;
  logic [15:0] frames_done;
  logic        line_level;

  fst_pkg::result_t expected_results [$];
  int               errors = 0;

  function automatic logic [7:0] ones_of(input logic [7:0] b);
    logic [7:0] n;
    n = 8'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {7'd0, b[i]};
    end
    return n;
  endfunction

  task automatic predict_line(input fst_pkg::item_t it, output fst_pkg::result_t r);
    logic [7:0] cur;
    logic       done;
    logic       rej;
    done = 1'b0;
    rej  = 1'b0;
    case (it.op)
      fst_pkg::OP_LOAD: begin
        if (in_frame || msg_len >= MAX_PAYLOAD) begin
          rej = 1'b1;
        end else begin
          msg_bytes[msg_len] = it.data_byte;
          msg_len = msg_len + 4'd1;
          ones_total = ones_total + ones_of(it.data_byte);
        end
      end
      fst_pkg::OP_START: begin
        if (in_frame) begin
          rej = 1'b1;
        end else begin
          hdr_byte = {msg_len, it.cmd};
          ones_total = ones_total + ones_of(hdr_byte);
          tick_in_byte = 4'd0;
          byte_index = 5'd0;
          in_frame = 1'b1;
        end
      end
      fst_pkg::OP_TICK: begin
        if (!in_frame) begin
          line_level = 1'b1;
        end else begin
          if (byte_index == 5'd0) begin
            cur = hdr_byte;
          end else if (byte_index <= {1'b0, msg_len}) begin
            cur = msg_bytes[byte_index[3:0] - 4'd1];
          end else begin
            cur = ones_total;
          end
          if (tick_in_byte == fst_pkg::BIT_START) begin
            line_level = 1'b0;
          end else if (tick_in_byte < fst_pkg::BIT_PARITY) begin
            line_level = cur[tick_in_byte - 4'd1];
          end else if (tick_in_byte == fst_pkg::BIT_PARITY) begin
            line_level = ^cur;
          end else begin
            line_level = 1'b1;
          end
          tick_in_byte = tick_in_byte + 4'd1;
          if (tick_in_byte >= fst_pkg::TICKS_PER_BYTE) begin
            tick_in_byte = 4'd0;
            byte_index = byte_index + 5'd1;
            if (byte_index >= {1'b0, msg_len} + 5'd2) begin
              in_frame = 1'b0;
              byte_index = 5'd0;
              msg_len = 4'd0;
              ones_total = 8'd0;
              frames_done = frames_done + 16'd1;
              done = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.tx_line     = line_level;
    r.busy_res    = in_frame;
    r.frame_done  = done;
    r.rejected    = rej;
    r.frames_sent = frames_done;
  endtask

  always @(posedge clk) begin
    fst_pkg::result_t want;
    fst_pkg::result_t next_want;
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        msg_bytes[i] = 8'd0;
      end
      msg_len = 4'd0;
      hdr_byte = 8'd0;
      ones_total = 8'd0;
      tick_in_byte = 4'd0;
      byte_index = 5'd0;
      in_frame = 1'b0;
      frames_done = 16'd0;
      line_level = 1'b1;
      expected_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result with no transaction outstanding: line=%0b busy=%0b done=%0b rej=%0b frames=%0d",
                     $time, result.tx_line, result.busy_res, result.frame_done,
                     result.rejected, result.frames_sent);
          end
        end else begin
          want = expected_results.pop_front();
          if (result.tx_line !== want.tx_line || result.busy_res !== want.busy_res ||
              result.frame_done !== want.frame_done || result.rejected !== want.rejected ||
              result.frames_sent !== want.frames_sent) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch: expected line=%0b busy=%0b done=%0b rej=%0b frames=%0d",
                       $time, want.tx_line, want.busy_res, want.frame_done, want.rejected,
                       want.frames_sent);
              $display("%0t:           actual   line=%0b busy=%0b done=%0b rej=%0b frames=%0d",
                       $time, result.tx_line, result.busy_res, result.frame_done,
                       result.rejected, result.frames_sent);
            end
          end
        end
      end
      if (item_valid && item_ready) begin
        predict_line(item, next_want);
        expected_results.push_back(next_want);
      end
    end
    mismatches  <= errors;
    outstanding <= expected_results.size();
  end

endmodule

/* tb/sv/tb_framed_serial_transmitter.sv */
module tb_framed_serial_transmitter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         MAX_PAYLOAD = 15;
  localparam logic [1:0] OP_NOP      = 2'd3;
  localparam int         ITEM_TARGET = 1650;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         BYTE_TICKS  = 12;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_ready;
  fst_pkg::item_t   item;
  logic             result_valid;
  logic             result_ready;
  fst_pkg::result_t result;
  int               mismatches;
  int               outstanding;

  int cycle_count = 0;
  int items_sent = 0;
  int useful_items = 0;
  int frames_started = 0;
  int rejects_driven = 0;
  int queued = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  framed_serial_transmitter #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  fst_line_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) line_check (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               outstanding);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send(input logic [1:0] op, input logic [3:0] cmd, input logic [7:0] data);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{op: op, cmd: cmd, data_byte: data};
    do @(posedge clk); while (!(item_valid && item_ready));
    items_sent++;
  endtask

  task automatic load_byte(input logic [7:0] data);
    send(fst_pkg::OP_LOAD, 4'($urandom_range(0, 15)), data);
    if (queued < MAX_PAYLOAD) begin
      queued++;
      useful_items++;
    end else begin
      rejects_driven++;
    end
  endtask

  task automatic idle_noise();
    case ($urandom_range(0, 2))
      0: load_byte(8'($urandom_range(0, 255)));
      1: send(fst_pkg::OP_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      default: send(OP_NOP, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endcase
  endtask

  // Every load and start issued here lands while a frame is on the line.
  task automatic busy_noise();
    logic [1:0] op;
    case ($urandom_range(0, 2))
      0: op = fst_pkg::OP_LOAD;
      1: op = fst_pkg::OP_START;
      default: op = OP_NOP;
    endcase
    if (op != OP_NOP) begin
      rejects_driven++;
    end
    send(op, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
  endtask

  task automatic run_frame(input int loads, input logic [3:0] cmd, input int noise_pct);
    int ticks;
    for (int i = 0; i < loads; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        idle_noise();
      end
      load_byte(8'($urandom_range(0, 255)));
    end
    send(fst_pkg::OP_START, cmd, 8'($urandom_range(0, 255)));
    frames_started++;
    useful_items++;
    ticks = (queued + 2) * BYTE_TICKS;
    queued = 0;
    for (int t = 0; t < ticks; t++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        busy_noise();
      end
      send(fst_pkg::OP_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      useful_items++;
    end
  endtask

  initial begin : result_sink
    int stall;
    forever begin
      if ($urandom_range(0, 49) == 0) begin
        rx_calm = !rx_calm;
      end
      stall = rx_calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  initial begin : stimulus
    int loads;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send(fst_pkg::OP_TICK, 4'h0, 8'h00);
    send(OP_NOP, 4'hF, 8'hFF);
    send(OP_NOP, 4'h0, 8'h00);
    run_frame(0, 4'hF, 100);
    load_byte(8'h00);
    load_byte(8'hFF);
    run_frame(MAX_PAYLOAD, 4'h0, 0);

    while (useful_items < ITEM_TARGET) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) idle_noise();
      end else begin
        loads = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 18) : $urandom_range(0, 4);
        run_frame(loads, 4'($urandom_range(0, 15)), $urandom_range(0, 1) ? 0 : 8);
      end
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Drove %0d transactions: %0d frames of 0 to 15 payload bytes, %0d loads",
             items_sent, frames_started, rejects_driven);
    $display("and starts aimed at a busy or full transmitter; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
